// ===== hdl/sgr_attribute_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// SGR attribute decoder: assertion macros
// Shared concurrent assertion forms, reset-qualified on an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SGR_ATTRIBUTE_DECODER_DEFINES_SVH
`define SGR_ATTRIBUTE_DECODER_DEFINES_SVH

// Same-cycle implication.
`define SGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sgr_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// SGR decoder package
// Attribute and pending-color types, SGR code values and color kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgr_dec_pkg;

  localparam int OUT_TDATA_W = 96;

  // color kinds, bits 25:24 of a color
  localparam logic [1:0] KIND_DEFAULT = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_RGB     = 2'd2;

  localparam logic [1:0] WEIGHT_NORMAL = 2'd0;
  localparam logic [1:0] WEIGHT_BOLD   = 2'd1;
  localparam logic [1:0] WEIGHT_DIM    = 2'd2;

  localparam logic [1:0] UL_NONE   = 2'd0;
  localparam logic [1:0] UL_SINGLE = 2'd1;
  localparam logic [1:0] UL_DOUBLE = 2'd2;

  localparam logic [1:0] BLINK_NONE   = 2'd0;
  localparam logic [1:0] BLINK_NORMAL = 2'd1;
  localparam logic [1:0] BLINK_RAPID  = 2'd2;

  // style flag bit positions
  localparam int FLAG_ITALIC   = 0;
  localparam int FLAG_INVERSE  = 1;
  localparam int FLAG_HIDDEN   = 2;
  localparam int FLAG_STRIKE   = 3;
  localparam int FLAG_OVERLINE = 4;

  localparam logic [7:0] BYTE_MAX = 8'd255;

  // SGR codes
  localparam logic [31:0] SGR_RESET         = 32'd0;
  localparam logic [31:0] SGR_BOLD          = 32'd1;
  localparam logic [31:0] SGR_DIM           = 32'd2;
  localparam logic [31:0] SGR_ITALIC        = 32'd3;
  localparam logic [31:0] SGR_UNDERLINE     = 32'd4;
  localparam logic [31:0] SGR_BLINK         = 32'd5;
  localparam logic [31:0] SGR_RAPID_BLINK   = 32'd6;
  localparam logic [31:0] SGR_INVERSE       = 32'd7;
  localparam logic [31:0] SGR_HIDDEN        = 32'd8;
  localparam logic [31:0] SGR_STRIKE        = 32'd9;
  localparam logic [31:0] SGR_DOUBLE_UL     = 32'd21;
  localparam logic [31:0] SGR_NORMAL_WEIGHT = 32'd22;
  localparam logic [31:0] SGR_NO_ITALIC     = 32'd23;
  localparam logic [31:0] SGR_NO_UL         = 32'd24;
  localparam logic [31:0] SGR_NO_BLINK      = 32'd25;
  localparam logic [31:0] SGR_NO_INVERSE    = 32'd27;
  localparam logic [31:0] SGR_NO_HIDDEN     = 32'd28;
  localparam logic [31:0] SGR_NO_STRIKE     = 32'd29;
  localparam logic [31:0] SGR_FG_BASE       = 32'd30;
  localparam logic [31:0] SGR_FG_EXT        = 32'd38;
  localparam logic [31:0] SGR_FG_DEFAULT    = 32'd39;
  localparam logic [31:0] SGR_BG_BASE       = 32'd40;
  localparam logic [31:0] SGR_BG_EXT        = 32'd48;
  localparam logic [31:0] SGR_BG_DEFAULT    = 32'd49;
  localparam logic [31:0] SGR_OVERLINE      = 32'd53;
  localparam logic [31:0] SGR_NO_OVERLINE   = 32'd55;
  localparam logic [31:0] SGR_LINE_EXT      = 32'd58;
  localparam logic [31:0] SGR_LINE_DEFAULT  = 32'd59;
  localparam logic [31:0] SGR_FG_BRIGHT     = 32'd90;
  localparam logic [31:0] SGR_BG_BRIGHT     = 32'd100;
  localparam logic [31:0] SGR_RGB_MODE      = 32'd2;
  localparam logic [31:0] PALETTE_SPAN      = 32'd7;
  localparam logic [31:0] BRIGHT_OFFSET     = 32'd8;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_FORE = 2'd1,
    TGT_BACK = 2'd2,
    TGT_LINE = 2'd3
  } target_t;

  typedef struct packed {
    target_t    target;
    logic [1:0] count;
  } pending_t;

  typedef struct packed {
    logic [1:0]  weight;
    logic [1:0]  underline_kind;
    logic [1:0]  blink_kind;
    logic [4:0]  style_flags;
    logic [25:0] fore_color;
    logic [25:0] back_color;
    logic [25:0] line_color;
  } attr_t;

endpackage

// ===== hdl/sgr_attribute_decoder.sv =====
// Usage: feed the numeric parameters of one SGR sequence on the in_ channel,
// one word per cycle, with in_tlast high on the final parameter. An empty
// sequence is sent as a single word of 0. The block keeps the text
// attributes across sequences and, for each word with in_tlast, returns the
// full attribute set as one word on the out_ channel; other words give none.
// The result word is registered: its last parameter passes the input
// register, then the decode, and is written to the result register.
// Throughput: one parameter per cycle, set by the single decode stage that
// updates the attribute registers, as long as no last word waits for the
// result register; the input register keeps accepting non-last words while
// a result waits to be taken.
// Reset (rst_n low, synchronous) clears all attributes to default/off,
// drops any pending extended-color run and empties both registers.
// When out_tready is low with a result held, non-last words still drain and
// update state; a further last word waits in the input register and
// in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
// SGR attribute decoder
// Top level: input register, decode update, attribute state, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sgr_attribute_decoder_defines.svh"

module sgr_attribute_decoder
  import sgr_dec_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // [VALUE_WIDTH-1:0] param_value
  input  logic                                in_tlast,   // is_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // weight[1:0], underline_kind[3:2], blink_kind[5:4], style_flags[10:6],
  // fore_color[36:11], back_color[62:37], line_color[88:63]
  output logic [OUT_TDATA_W-1:0]              out_tdata
);

  logic                   s1_valid;
  logic [VALUE_WIDTH-1:0] s1_value;
  logic                   s1_last;
  logic                   take;

  attr_t                  attr_r, attr_nxt;
  pending_t               pend_r, pend_nxt;
  logic [VALUE_WIDTH-1:0] held0_r, held0_nxt;
  logic [VALUE_WIDTH-1:0] held1_r, held1_nxt;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  sgr_dec_in_reg #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[VALUE_WIDTH-1:0]),
    .in_last  (in_tlast),
    .take_i   (take),
    .valid_o  (s1_valid),
    .value_o  (s1_value),
    .last_o   (s1_last)
  );

  // a last word needs a free result register
  assign take = s1_valid && (!s1_last || !out_valid_r || out_tready);

  sgr_dec_update #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_update (
    .value_i (s1_value),
    .last_i  (s1_last),
    .attr_i  (attr_r),
    .pend_i  (pend_r),
    .held0_i (held0_r),
    .held1_i (held1_r),
    .attr_o  (attr_nxt),
    .pend_o  (pend_nxt),
    .held0_o (held0_nxt),
    .held1_o (held1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= '0;
      pend_r <= '{target: TGT_NONE, count: 2'd0};
    end else if (take) begin
      attr_r <= attr_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && s1_last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_last) begin
      out_data_r <= {7'd0, attr_nxt.line_color, attr_nxt.back_color, attr_nxt.fore_color,
                     attr_nxt.style_flags, attr_nxt.blink_kind, attr_nxt.underline_kind,
                     attr_nxt.weight};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SGR_ASSERT_SAME(a_idle_count_zero, clk, rst_n, pend_r.target == TGT_NONE,
    pend_r.count == 2'd0, "pending count set with no color target")
  `SGR_ASSERT_NEXT(a_last_ends_run, clk, rst_n, take && s1_last,
    out_valid_r && pend_r.target == TGT_NONE, "last word left a run open or no result")
  `SGR_ASSERT_NEXT(a_state_holds, clk, rst_n, !take,
    $stable(attr_r) && $stable(pend_r), "attributes changed without a word")

endmodule

// ===== hdl/sgr_dec_in_reg.sv =====
// ----------------------------------------------------------------------------
// SGR decoder input register
// Holds one parameter word until the decode stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgr_dec_in_reg #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_last,
  input  logic                   take_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   last_o
);

  logic                   valid_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   last_r;

  assign in_ready = !valid_r || take_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
  end

  assign valid_o = valid_r;
  assign value_o = value_r;
  assign last_o  = last_r;

endmodule

// ===== hdl/sgr_dec_update.sv =====
// ----------------------------------------------------------------------------
// SGR decoder update logic
// Next attribute, pending and held state for one parameter word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgr_dec_update
  import sgr_dec_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_i,
  input  attr_t                  attr_i,
  input  pending_t               pend_i,
  input  logic [VALUE_WIDTH-1:0] held0_i,
  input  logic [VALUE_WIDTH-1:0] held1_i,
  output attr_t                  attr_o,
  output pending_t               pend_o,
  output logic [VALUE_WIDTH-1:0] held0_o,
  output logic [VALUE_WIDTH-1:0] held1_o
);

  function automatic logic [7:0] clamp_byte(logic [31:0] x);
    return (x > 32'(BYTE_MAX)) ? BYTE_MAX : x[7:0];
  endfunction

  function automatic attr_t apply_plain(attr_t s, logic [31:0] c);
    attr_t r;
    r = s;
    if (c >= SGR_FG_BASE && c <= SGR_FG_BASE + PALETTE_SPAN) begin
      r.fore_color = {KIND_PALETTE, 20'd0, 4'(c - SGR_FG_BASE)};
    end else if (c >= SGR_BG_BASE && c <= SGR_BG_BASE + PALETTE_SPAN) begin
      r.back_color = {KIND_PALETTE, 20'd0, 4'(c - SGR_BG_BASE)};
    end else if (c >= SGR_FG_BRIGHT && c <= SGR_FG_BRIGHT + PALETTE_SPAN) begin
      r.fore_color = {KIND_PALETTE, 20'd0, 4'(c - SGR_FG_BRIGHT + BRIGHT_OFFSET)};
    end else if (c >= SGR_BG_BRIGHT && c <= SGR_BG_BRIGHT + PALETTE_SPAN) begin
      r.back_color = {KIND_PALETTE, 20'd0, 4'(c - SGR_BG_BRIGHT + BRIGHT_OFFSET)};
    end else begin
      unique case (c)
        SGR_RESET:         r = '0;
        SGR_BOLD:          r.weight = WEIGHT_BOLD;
        SGR_DIM:           r.weight = WEIGHT_DIM;
        SGR_ITALIC:        r.style_flags[FLAG_ITALIC] = 1'b1;
        SGR_UNDERLINE:     r.underline_kind = UL_SINGLE;
        SGR_BLINK:         r.blink_kind = BLINK_NORMAL;
        SGR_RAPID_BLINK:   r.blink_kind = BLINK_RAPID;
        SGR_INVERSE:       r.style_flags[FLAG_INVERSE] = 1'b1;
        SGR_HIDDEN:        r.style_flags[FLAG_HIDDEN] = 1'b1;
        SGR_STRIKE:        r.style_flags[FLAG_STRIKE] = 1'b1;
        SGR_DOUBLE_UL:     r.underline_kind = UL_DOUBLE;
        SGR_NORMAL_WEIGHT: r.weight = WEIGHT_NORMAL;
        SGR_NO_ITALIC:     r.style_flags[FLAG_ITALIC] = 1'b0;
        SGR_NO_UL:         r.underline_kind = UL_NONE;
        SGR_NO_BLINK:      r.blink_kind = BLINK_NONE;
        SGR_NO_INVERSE:    r.style_flags[FLAG_INVERSE] = 1'b0;
        SGR_NO_HIDDEN:     r.style_flags[FLAG_HIDDEN] = 1'b0;
        SGR_NO_STRIKE:     r.style_flags[FLAG_STRIKE] = 1'b0;
        SGR_FG_DEFAULT:    r.fore_color = {KIND_DEFAULT, 24'd0};
        SGR_BG_DEFAULT:    r.back_color = {KIND_DEFAULT, 24'd0};
        SGR_OVERLINE:      r.style_flags[FLAG_OVERLINE] = 1'b1;
        SGR_NO_OVERLINE:   r.style_flags[FLAG_OVERLINE] = 1'b0;
        SGR_LINE_DEFAULT:  r.line_color = {KIND_DEFAULT, 24'd0};
        default:           r = s;
      endcase
    end
    return r;
  endfunction

  logic [31:0] v32;
  logic [25:0] rgb_color;
  logic        plain;
  logic [1:0]  replay_n;

  assign v32       = 32'(value_i);
  assign rgb_color = {KIND_RGB, clamp_byte(32'(held0_i)), clamp_byte(32'(held1_i)),
                      clamp_byte(v32)};

  always_comb begin
    attr_o   = attr_i;
    pend_o   = pend_i;
    held0_o  = held0_i;
    held1_o  = held1_i;
    plain    = 1'b1;
    replay_n = 2'd0;

    if (pend_i.target != TGT_NONE) begin
      plain = 1'b0;
      unique case (pend_i.count)
        2'd0: begin
          if (v32 != SGR_RGB_MODE) begin
            // selector without rgb mode: drop it, decode this word as a code
            pend_o = '{target: TGT_NONE, count: 2'd0};
            plain  = 1'b1;
          end else begin
            pend_o.count = 2'd1;
          end
        end
        2'd1: begin
          held0_o      = value_i;
          pend_o.count = 2'd2;
        end
        2'd2: begin
          held1_o      = value_i;
          pend_o.count = 2'd3;
        end
        default: begin
          unique case (pend_i.target)
            TGT_FORE: attr_o.fore_color = rgb_color;
            TGT_BACK: attr_o.back_color = rgb_color;
            default:  attr_o.line_color = rgb_color;
          endcase
          pend_o = '{target: TGT_NONE, count: 2'd0};
        end
      endcase
    end

    if (plain) begin
      if (v32 == SGR_FG_EXT || v32 == SGR_BG_EXT || v32 == SGR_LINE_EXT) begin
        if (!last_i) begin
          pend_o.count = 2'd0;
          if (v32 == SGR_FG_EXT) begin
            pend_o.target = TGT_FORE;
          end else if (v32 == SGR_BG_EXT) begin
            pend_o.target = TGT_BACK;
          end else begin
            pend_o.target = TGT_LINE;
          end
        end
      end else begin
        attr_o = apply_plain(attr_o, v32);
      end
    end

    // sequence ended inside 2;r;g;b: replay the words taken as plain codes
    if (last_i && pend_o.target != TGT_NONE) begin
      replay_n = pend_o.count;
      pend_o   = '{target: TGT_NONE, count: 2'd0};
      if (replay_n >= 2'd1) begin
        attr_o = apply_plain(attr_o, SGR_RGB_MODE);
      end
      if (replay_n >= 2'd2) begin
        attr_o = apply_plain(attr_o, 32'(held0_o));
      end
      if (replay_n >= 2'd3) begin
        attr_o = apply_plain(attr_o, 32'(held1_o));
      end
    end
  end

endmodule
